// ----- design/bpc_pkg.sv -----
package bpc_pkg;

   // register indexes on the csr port
   localparam logic [2:0] REG_OSS = 3'd0;
   localparam logic [2:0] REG_AC1 = 3'd1;
   localparam logic [2:0] REG_AC2 = 3'd2;
   localparam logic [2:0] REG_AC3 = 3'd3;
   localparam logic [2:0] REG_AC4 = 3'd4;
   localparam logic [2:0] REG_B1  = 3'd5;
   localparam logic [2:0] REG_B2  = 3'd6;

   // reset values of the calibration registers
   localparam logic [1:0]  OSS_RESET = 2'd3;
   localparam logic [15:0] AC1_RESET = 16'd408;
   localparam logic [15:0] AC2_RESET = 16'hFFB8;
   localparam logic [15:0] AC3_RESET = 16'hC7D1;
   localparam logic [15:0] AC4_RESET = 16'd32741;
   localparam logic [15:0] B1_RESET  = 16'd6190;
   localparam logic [15:0] B2_RESET  = 16'd4;

   // formula constants
   localparam logic signed [31:0] B5_OFFSET  = 32'sd4000;
   localparam logic signed [31:0] B4_BIAS    = 32'sd32768;
   localparam logic [31:0]        B7_SCALE   = 32'd50000;
   localparam logic signed [31:0] C_X1       = 32'sd3038;
   localparam logic signed [31:0] C_X2       = -32'sd7357;
   localparam logic signed [31:0] C_OFS      = 32'sd3791;
   localparam logic signed [31:0] PA_MAX     = 32'sd262143;

   localparam int DIV_W = 32;

   // calibration set as seen by the datapath
   typedef struct packed {
      logic [1:0]  oss;
      logic [15:0] ac1;
      logic [15:0] ac2;
      logic [15:0] ac3;
      logic [15:0] ac4;
      logic [15:0] b1;
      logic [15:0] b2;
   } cal_type;

   // side flags that travel through the divider
   typedef struct packed {
      logic dbl;
      logic zero;
   } div_tag_type;

   // sign extend a 16 bit word to 32 bits
   function automatic logic signed [31:0] sx16(input logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

   // signed divide by 2**k, truncating toward zero
   function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] x,
                                                  input logic [4:0] k);
      logic signed [31:0] bias;
      bias = x[31] ? ~({32{1'b1}} << k) : '0;
      return (x + bias) >>> k;
   endfunction

endpackage

// ----- design/bpc_front.sv -----
module bpc_front import bpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [18:0]        raw_pressure,
   input  logic signed [20:0] temp_b5,
   input  cal_type            cal,
   output logic               out_valid,
   output logic [31:0]        b7,
   output logic [31:0]        b4
);

   logic [3:0] v_ff;

   logic signed [31:0] b6_c;
   logic signed [31:0] s1_b6b6_ff, s1_ac2b6_ff, s1_ac3b6_ff;
   logic [18:0]        s1_raw_ff, s2_raw_ff, s3_raw_ff;

   logic signed [31:0] sq_c;
   logic signed [31:0] s2_b2sq_ff, s2_b1sq_ff, s2_x2a_ff, s2_x1b_ff;

   logic signed [31:0] x3a_c, sh_c, x3b_c;
   logic signed [31:0] s3_b3_ff, s3_t_ff;

   logic [31:0] s4_b4_ff, s4_b7_ff;
   logic [31:0] b4_prod_c;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   // stage 1: b6 and its products
   assign b6_c = {{11{temp_b5[20]}}, temp_b5} - B5_OFFSET;

   always_ff @(posedge clock) begin
      s1_b6b6_ff  <= b6_c * b6_c;
      s1_ac2b6_ff <= sx16(cal.ac2) * b6_c;
      s1_ac3b6_ff <= sx16(cal.ac3) * b6_c;
      s1_raw_ff   <= raw_pressure;
   end

   // stage 2: square term and its products
   assign sq_c = sdiv_p2(s1_b6b6_ff, 5'd12);

   always_ff @(posedge clock) begin
      s2_b2sq_ff <= sx16(cal.b2) * sq_c;
      s2_b1sq_ff <= sx16(cal.b1) * sq_c;
      s2_x2a_ff  <= sdiv_p2(s1_ac2b6_ff, 5'd11);
      s2_x1b_ff  <= sdiv_p2(s1_ac3b6_ff, 5'd13);
      s2_raw_ff  <= s1_raw_ff;
   end

   // stage 3: offset b3 and divisor term
   assign x3a_c = sdiv_p2(s2_b2sq_ff, 5'd11) + s2_x2a_ff;
   assign sh_c  = ((sx16(cal.ac1) <<< 2) + x3a_c) << cal.oss;
   assign x3b_c = sdiv_p2(s2_x1b_ff + sdiv_p2(s2_b1sq_ff, 5'd16) + 32'sd2, 5'd2);

   always_ff @(posedge clock) begin
      s3_b3_ff  <= sdiv_p2(sh_c + 32'sd2, 5'd2);
      s3_t_ff   <= x3b_c + B4_BIAS;
      s3_raw_ff <= s2_raw_ff;
   end

   // stage 4: divisor b4 and scaled reading b7
   assign b4_prod_c = {16'd0, cal.ac4} * s3_t_ff;

   always_ff @(posedge clock) begin
      s4_b4_ff <= b4_prod_c >> 15;
      s4_b7_ff <= ({13'd0, s3_raw_ff} - s3_b3_ff) * (B7_SCALE >> cal.oss);
   end

   assign out_valid = v_ff[3];
   assign b7        = s4_b7_ff;
   assign b4        = s4_b4_ff;

endmodule

// ----- design/bpc_div.sv -----
module bpc_div import bpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DIV_W-1:0]  num,
   input  logic [DIV_W-1:0]  den,
   input  div_tag_type       in_tag,
   output logic              out_valid,
   output logic [DIV_W-1:0]  quo,
   output div_tag_type       out_tag
);

   logic [DIV_W-1:0] rem_ff [DIV_W];
   logic [DIV_W-1:0] nq_ff  [DIV_W];
   logic [DIV_W-1:0] den_ff [DIV_W];
   div_tag_type      tag_ff [DIV_W];
   logic [DIV_W-1:0] v_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[DIV_W-2:0], in_valid};
      end
   end

   // one quotient bit per stage, restoring
   for (genvar i = 0; i < DIV_W; i++) begin : g_step
      logic [DIV_W-1:0] rem_c;
      logic [DIV_W-1:0] nq_c;
      logic [DIV_W-1:0] den_c;
      div_tag_type      tag_c;
      logic [DIV_W:0]   rs_c;
      logic             ge_c;
      logic [DIV_W:0]   diff_c;

      // stage inputs: divider ports for the first stage, else the previous stage
      if (i == 0) begin : g_first
         assign rem_c = '0;
         assign nq_c  = num;
         assign den_c = den;
         assign tag_c = in_tag;
      end else begin : g_next
         assign rem_c = rem_ff[i-1];
         assign nq_c  = nq_ff[i-1];
         assign den_c = den_ff[i-1];
         assign tag_c = tag_ff[i-1];
      end

      assign rs_c   = {rem_c, nq_c[DIV_W-1]};
      assign ge_c   = rs_c >= {1'b0, den_c};
      assign diff_c = rs_c - {1'b0, den_c};

      always_ff @(posedge clock) begin
         rem_ff[i] <= ge_c ? diff_c[DIV_W-1:0] : rs_c[DIV_W-1:0];
         nq_ff[i]  <= {nq_c[DIV_W-2:0], ge_c};
         den_ff[i] <= den_c;
         tag_ff[i] <= tag_c;
      end
   end

   assign out_valid = v_ff[DIV_W-1];
   assign quo       = nq_ff[DIV_W-1];
   assign out_tag   = tag_ff[DIV_W-1];

endmodule

// ----- design/bpc_back.sv -----
module bpc_back import bpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] quo,
   input  div_tag_type tag,
   output logic        out_valid,
   output logic [17:0] pressure_pa
);

   logic [2:0] v_ff;

   logic signed [31:0] p_c, h_c;
   logic signed [31:0] b1_hh_ff, b1_m2_ff, b1_p_ff;
   logic signed [31:0] b2_m1_ff, b2_x2_ff, b2_p_ff;
   logic               b1_zero_ff, b2_zero_ff;
   logic signed [31:0] pf_c;
   logic [17:0]        out_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   // stage 1: raw pressure and first products
   assign p_c = tag.dbl ? {quo[30:0], 1'b0} : quo;
   assign h_c = sdiv_p2(p_c, 5'd8);

   always_ff @(posedge clock) begin
      b1_hh_ff   <= h_c * h_c;
      b1_m2_ff   <= p_c * C_X2;
      b1_p_ff    <= p_c;
      b1_zero_ff <= tag.zero;
   end

   // stage 2: second order product
   always_ff @(posedge clock) begin
      b2_m1_ff   <= b1_hh_ff * C_X1;
      b2_x2_ff   <= sdiv_p2(b1_m2_ff, 5'd16);
      b2_p_ff    <= b1_p_ff;
      b2_zero_ff <= b1_zero_ff;
   end

   // stage 3: correction and saturation
   assign pf_c = b2_p_ff +
                 sdiv_p2(sdiv_p2(b2_m1_ff, 5'd16) + b2_x2_ff + C_OFS, 5'd4);

   always_ff @(posedge clock) begin
      if (b2_zero_ff || (!pf_c[31] && pf_c > PA_MAX)) begin
         out_ff <= PA_MAX[17:0];
      end else if (pf_c[31]) begin
         out_ff <= '0;
      end else begin
         out_ff <= pf_c[17:0];
      end
   end

   assign out_valid   = v_ff[2];
   assign pressure_pa = out_ff;

   // zero divisor gives the saturated value
   a_zero_sat: assert property (@(posedge clock) disable iff (reset)
      (v_ff[1] && b2_zero_ff) |=> (out_valid && pressure_pa == PA_MAX[17:0]))
      else $error("zero divisor not saturated");

   // negative corrected pressure clamps to zero
   a_neg_clamp: assert property (@(posedge clock) disable iff (reset)
      (v_ff[1] && !b2_zero_ff && pf_c[31]) |=> (pressure_pa == '0))
      else $error("negative pressure not clamped");

endmodule

// ----- design/barometric_pressure_compensation.sv -----
// pipelined pressure compensation: accepts one request every clock cycle
// result strobe rsp_valid rises once the accepted request has passed through all stages
// (4 front stages, 32 divider stages of one quotient bit each, 3 back stages)
// busy stays low, the receiver cannot stall; synchronous active high reset
// clears the pipeline valid bits and loads the calibration defaults
module barometric_pressure_compensation import bpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [18:0] req_raw_pressure,
   input  logic [20:0] req_temp_b5,
   output logic        rsp_valid,
   output logic [17:0] rsp_pressure_pa,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cal_type     cal_ff;
   logic        wr_c;
   logic [2:0]  idx_c;

   logic        fr_valid;
   logic [31:0] fr_b7, fr_b4;
   div_tag_type dv_tag_in, dv_tag_out;
   logic [31:0] dv_num, dv_quo;
   logic        dv_valid;

   // csr write
   assign wr_c   = psel && penable && pwrite && pready;
   assign idx_c  = paddr[4:2];
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.oss <= OSS_RESET;
         cal_ff.ac1 <= AC1_RESET;
         cal_ff.ac2 <= AC2_RESET;
         cal_ff.ac3 <= AC3_RESET;
         cal_ff.ac4 <= AC4_RESET;
         cal_ff.b1  <= B1_RESET;
         cal_ff.b2  <= B2_RESET;
      end else if (wr_c) begin
         case (idx_c)
            REG_OSS: cal_ff.oss <= pwdata[1:0];
            REG_AC1: cal_ff.ac1 <= pwdata[15:0];
            REG_AC2: cal_ff.ac2 <= pwdata[15:0];
            REG_AC3: cal_ff.ac3 <= pwdata[15:0];
            REG_AC4: cal_ff.ac4 <= pwdata[15:0];
            REG_B1:  cal_ff.b1  <= pwdata[15:0];
            REG_B2:  cal_ff.b2  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // csr read
   always_comb begin
      case (idx_c)
         REG_OSS: prdata = {30'd0, cal_ff.oss};
         REG_AC1: prdata = {16'd0, cal_ff.ac1};
         REG_AC2: prdata = {16'd0, cal_ff.ac2};
         REG_AC3: prdata = {16'd0, cal_ff.ac3};
         REG_AC4: prdata = {16'd0, cal_ff.ac4};
         REG_B1:  prdata = {16'd0, cal_ff.b1};
         REG_B2:  prdata = {16'd0, cal_ff.b2};
         default: prdata = '0;
      endcase
   end

   assign busy = 1'b0;

   // b3, b4, b7
   bpc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start && !busy),
      .raw_pressure (req_raw_pressure),
      .temp_b5      (req_temp_b5),
      .cal          (cal_ff),
      .out_valid    (fr_valid),
      .b7           (fr_b7),
      .b4           (fr_b4)
   );

   // large b7 is divided first and doubled after
   assign dv_num         = fr_b7[31] ? fr_b7 : {fr_b7[30:0], 1'b0};
   assign dv_tag_in.dbl  = fr_b7[31];
   assign dv_tag_in.zero = (fr_b4 == '0);

   bpc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .num       (dv_num),
      .den       (fr_b4),
      .in_tag    (dv_tag_in),
      .out_valid (dv_valid),
      .quo       (dv_quo),
      .out_tag   (dv_tag_out)
   );

   bpc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dv_valid),
      .quo         (dv_quo),
      .tag         (dv_tag_out),
      .out_valid   (rsp_valid),
      .pressure_pa (rsp_pressure_pa)
   );

   // pipeline never pushes back
   a_no_busy: assert property (@(posedge clock) !busy)
      else $error("busy asserted");

   // oversampling register reads back two bits only
   a_oss_read: assert property (@(posedge clock) disable iff (reset)
      (idx_c == REG_OSS) |-> (prdata[31:2] == '0))
      else $error("oversampling readback too wide");

   // a write to the oversampling register lands
   a_oss_write: assert property (@(posedge clock) disable iff (reset)
      (wr_c && idx_c == REG_OSS) |=> (cal_ff.oss == $past(pwdata[1:0])))
      else $error("oversampling write lost");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import bpc_pkg::*;

   // register index with no register behind it
   localparam logic [2:0] REG_NONE = 3'd7;
   localparam int unsigned PRESSURE_MAX = 262143;
   localparam int PIPE_DRAIN = 60;

   // pressure predictor and store of expected pressures
   class pressure_board;
      logic [1:0]  oss;
      logic [15:0] ac1, ac2, ac3, ac4, b1, b2;
      int unsigned pending_pa[$];
      int          errors;

      function void load_defaults();
         oss = OSS_RESET;
         ac1 = AC1_RESET;
         ac2 = AC2_RESET;
         ac3 = AC3_RESET;
         ac4 = AC4_RESET;
         b1  = B1_RESET;
         b2  = B2_RESET;
         errors = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_OSS: oss = val[1:0];
            REG_AC1: ac1 = val[15:0];
            REG_AC2: ac2 = val[15:0];
            REG_AC3: ac3 = val[15:0];
            REG_AC4: ac4 = val[15:0];
            REG_B1:  b1  = val[15:0];
            REG_B2:  b2  = val[15:0];
            default: ;
         endcase
      endfunction

      // 32-bit compensation chain, wrapping like int arithmetic
      function int unsigned compensate(logic [18:0] raw, logic [20:0] b5_in);
         int b5, b6, sq, x1, x2, x3, b3, p, h;
         int unsigned sh, b4, b7, q, scale;
         b5 = {{11{b5_in[20]}}, b5_in};
         b6 = b5 - 4000;
         sq = (b6 * b6) / 4096;
         x1 = (int'(signed'(b2)) * sq) / 2048;
         x2 = (int'(signed'(ac2)) * b6) / 2048;
         x3 = x1 + x2;
         sh = int'(unsigned'(int'(signed'(ac1)) * 4 + x3)) << oss;
         b3 = (int'(sh) + 2) / 4;
         x1 = (int'(signed'(ac3)) * b6) / 8192;
         x2 = (int'(signed'(b1)) * sq) / 65536;
         x3 = ((x1 + x2) + 2) / 4;
         b4 = (int'(unsigned'(ac4)) * int'(unsigned'(x3 + 32768)));
         b4 = b4 / 32'd32768;
         scale = 32'd50000 >> oss;
         b7 = (32'(raw) - int'(unsigned'(b3))) * scale;
         if (b4 == 0)
            return PRESSURE_MAX;
         // b7 with the top bit set is divided first and doubled after
         if (b7 < 32'h8000_0000)
            q = (b7 * 2) / b4;
         else
            q = (b7 / b4) * 2;
         p  = int'(q);
         h  = p / 256;
         x1 = h * h;
         x1 = (x1 * 3038) / 65536;
         x2 = (-7357 * p) / 65536;
         p  = p + ((x1 + x2) + 3791) / 16;
         if (p < 0)
            return 0;
         if (p > int'(PRESSURE_MAX))
            return PRESSURE_MAX;
         return int'(unsigned'(p));
      endfunction

      function void note_request(logic [18:0] raw, logic [20:0] b5_in);
         pending_pa.push_back(compensate(raw, b5_in));
      endfunction

      function void check_pressure(logic [17:0] actual);
         int unsigned want;
         if (pending_pa.size() == 0) begin
            $error("pressure_pa: no request pending, actual %0d", actual);
            errors++;
            return;
         end
         want = pending_pa.pop_front();
         if (want != 32'(actual)) begin
            $error("pressure_pa: expected %0d, actual %0d", want, actual);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [18:0] req_raw_pressure = '0;
   logic [20:0] req_temp_b5 = '0;
   logic        rsp_valid;
   logic [17:0] rsp_pressure_pa;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   pressure_board board = new();

   barometric_pressure_compensation i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_raw_pressure(req_raw_pressure), .req_temp_b5(req_temp_b5),
      .rsp_valid(rsp_valid), .rsp_pressure_pa(rsp_pressure_pa),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // result monitor, values read before this edge updates them
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         board.check_pressure(rsp_pressure_pa);
   end

   // register write: setup cycle then access cycle
   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      board.set_reg(idx, val);
   endtask

   // one request, then an idle gap with start low
   task automatic send_request(logic [18:0] raw, logic [20:0] b5, int gap);
      start            <= 1'b1;
      req_raw_pressure <= raw;
      req_temp_b5      <= b5;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_request(raw, b5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending_pa.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic load_cal(logic [1:0] o, logic [15:0] a1, logic [15:0] a2,
                           logic [15:0] a3, logic [15:0] a4, logic [15:0] c1,
                           logic [15:0] c2);
      csr_write(REG_OSS, {30'd0, o});
      csr_write(REG_AC1, {16'd0, a1});
      csr_write(REG_AC2, {16'd0, a2});
      csr_write(REG_AC3, {16'd0, a3});
      csr_write(REG_AC4, {16'd0, a4});
      csr_write(REG_B1,  {16'd0, c1});
      csr_write(REG_B2,  {16'd0, c2});
   endtask

   // random request, mostly plausible readings, some over the full range
   task automatic random_request(bit burst);
      logic [18:0] raw;
      logic [20:0] b5;
      int          gap;
      if ($urandom_range(0, 3) == 0)
         raw = 19'($urandom);
      else
         raw = 19'($urandom_range(20000, 350000));
      if ($urandom_range(0, 3) == 0)
         b5 = 21'($urandom);
      else
         b5 = 21'($urandom_range(0, 16000) - 5000);
      gap = burst ? 0 : $urandom_range(0, 19);
      send_request(raw, b5, gap);
   endtask

   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      board.load_defaults();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes at reset calibration
      send_request(19'd0, 21'd0, 0);
      send_request(19'h7FFFF, 21'h0FFFFF, 1);
      send_request(19'd0, 21'h100000, 0);
      send_request(19'h7FFFF, 21'h100000, 3);
      send_request(19'd0, 21'h0FFFFF, 0);
      send_request(19'd40000, 21'd4000, 0);
      send_request(19'd23843, 21'd2400, 2);
      send_request(19'h55555, 21'h0AAAAA, 0);
      send_request(19'h2AAAA, 21'h155555, 0);
      drain();

      // zero divisor, out of range results, ignored register index
      load_cal(2'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd1, 16'd0, 16'h7FFF);
      csr_write(REG_NONE, 32'hFFFF_FFFF);
      send_request(19'd30000, -21'sd28768, 0);
      send_request(19'h7FFFF, -21'sd28768, 0);
      send_request(19'h7FFFF, 21'd4000, 2);
      send_request(19'd0, 21'd4000, 0);
      send_request(19'h7FFFF, 21'h100000, 0);
      send_request(19'd0, 21'h0FFFFF, 1);
      drain();
      load_cal(2'd3, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h8000, 16'h8000);
      send_request(19'd0, 21'd0, 0);
      send_request(19'h7FFFF, 21'h100000, 0);
      send_request(19'h7FFFF, 21'h0FFFFF, 0);
      send_request(19'd100000, 21'd4000, 0);
      send_request(19'd0, 21'h100000, 4);
      drain();

      // random phases over several calibrations
      for (int ph = 0; ph < 7; ph++) begin
         bit burst;
         case (ph)
            0: load_cal(OSS_RESET, AC1_RESET, AC2_RESET, AC3_RESET,
                        AC4_RESET, B1_RESET, B2_RESET);
            1: load_cal(2'd0, 16'd408, 16'hFFB8, 16'hC7D1, 16'd32741,
                        16'd6190, 16'd4);
            2: load_cal(2'd1, 16'h8000, 16'h8000, 16'h8000, 16'd1,
                        16'h8000, 16'h8000);
            3: load_cal(2'd2, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF,
                        16'h7FFF, 16'h7FFF);
            default: load_cal(2'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom_range(1, 65535)),
                              16'($urandom), 16'($urandom));
         endcase
         for (int n = 0; n < 60; n++) begin
            if (n % 20 == 0)
               burst = ($urandom_range(0, 2) == 0);
            random_request(burst);
            // hold off until the pipe is empty
            if (n == 30 && ph == 2) begin
               start <= 1'b0;
               @(posedge clock);
               while (board.pending_pa.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (board.errors == 0 && board.pending_pa.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
